>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define CLB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset.
`define CLB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/clb_pkg.sv
package clb_pkg;

	// Destination window size in pixels.
	localparam int WIN_WIDTH  = 1024;
	localparam int WIN_HEIGHT = 1024;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Register indexes on the config port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_X    = 3'd0,
		REG_DEST_Y    = 3'd1,
		REG_RECT_W    = 3'd2,
		REG_RECT_H    = 3'd3,
		REG_SRC_X     = 3'd4,
		REG_SRC_Y     = 3'd5,
		REG_SRC_WIDTH = 3'd6
	} reg_idx_t;

	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
	// floor(x/255) == (x * 0x8081) >> 23 for every x up to 255*255
	localparam logic [15:0] RECIP_255    = 16'h8081;

	// Current register view, rectangle sizes already clamped to 1..2048.
	typedef struct packed {
		logic [11:0] dest_x;     // signed
		logic [11:0] dest_y;     // signed
		logic [11:0] rect_w;
		logic [11:0] rect_h;
		logic [11:0] src_x;
		logic [11:0] src_y;
		logic [12:0] src_width;
	} cfg_t;

	// Raster position of the next request.
	typedef struct packed {
		logic [10:0] col;
		logic [10:0] row;
		logic        last;
	} pos_t;

	typedef enum logic [1:0] {
		PX_CLEAR,
		PX_COPY,
		PX_BLEND
	} px_kind_t;

	// Per-pixel blend partial results: kind and un-divided channel sums (R, G, B).
	typedef struct packed {
		px_kind_t         kind;
		logic [2:0][15:0] sum;
	} mix_t;

	// Clip and address partials for one position.
	typedef struct packed {
		logic        in_win;
		logic [19:0] dst_addr;
		logic [23:0] src_prod;
		logic [12:0] src_off;
	} addr_t;

	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(RECIP_255);
		return p[30:23];
	endfunction

endpackage

>>> hw/rtl/clipped_alpha_blit_unit.sv
// Alpha-blending blit datapath with window clipping. Program the seven
// registers (dest_x, dest_y, rect_w, rect_h, src_x, src_y, src_width) over
// the cfg port while no request is in flight, then stream one request per
// rectangle position in raster order: tdata carries the source ARGB pixel
// and the destination pixel currently at that spot. The unit keeps the
// column/row counters itself and returns one result per request with the
// write flag, destination and source word addresses, the colour and tlast on
// the final position. Clipped positions and alpha 0 give no write; alpha 255
// copies the source; other alphas blend each channel and force alpha to 0xFF.
// Throughput is one request per clock with no bubbles while m_tready is held
// high; the stages are the input register, product stage and output register,
// split around the per-channel and reciprocal (divide by 255) multiplies.
// The counters wrap back to the origin after the last position, so
// consecutive rectangles stream without any restart.
`include "assert_macros.svh"

module clipped_alpha_blit_unit import clb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,   // src_pixel[31:0], dst_pixel[63:32]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [79:0]           m_tdata,   // write_enable[0], dst_addr[20:1],
	                                         // src_addr[44:21], out_pixel[76:45], zero[79:77]
	output logic                  m_tlast
);

	cfg_t  cfg;
	pos_t  pos;
	addr_t addr;
	mix_t  mix;

	logic  accept;
	logic  rdy_o, rdy_s2, rdy_s1;

	// stage 1: captured request and its position
	logic        v_s1;
	logic [31:0] sp_s1, dp_s1;
	logic [10:0] col_s1, row_s1;
	logic        last_s1;

	// stage 2: products
	logic        v_s2;
	addr_t       addr_s2;
	mix_t        mix_s2;
	logic [31:0] sp_s2;
	logic        last_s2;

	// output register
	logic        out_valid_q;
	logic        we_q;
	logic [19:0] dst_addr_q;
	logic [23:0] src_addr_q;
	logic [31:0] pix_q;
	logic        last_q;

	logic        we_nx;
	logic [31:0] pix_nx;

	clb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clb_walker u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (accept),
		.pos    (pos)
	);

	// each stage loads whenever it is empty or the one after it can make room
	assign rdy_o    = !out_valid_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_o;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign accept   = s_tvalid && rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sp_s1   <= s_tdata[31:0];
			dp_s1   <= s_tdata[63:32];
			col_s1  <= pos.col;
			row_s1  <= pos.row;
			last_s1 <= pos.last;
		end
	end

	// user keeps config stable with requests in flight (unchecked); later stages read it live
	clb_addr_gen u_addr (
		.cfg  (cfg),
		.col  (col_s1),
		.row  (row_s1),
		.addr (addr)
	);

	clb_mix u_mix (
		.src_pixel (sp_s1),
		.dst_pixel (dp_s1),
		.mix       (mix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			addr_s2 <= addr;
			mix_s2  <= mix;
			sp_s2   <= sp_s1;
			last_s2 <= last_s1;
		end
	end

	// final colour: divide by 255 through the reciprocal multiply
	assign we_nx = addr_s2.in_win && (mix_s2.kind != PX_CLEAR);

	always_comb begin
		if (!we_nx) begin
			pix_nx = '0;
		end else begin
			unique case (mix_s2.kind)
				PX_COPY:  pix_nx = sp_s2;
				PX_BLEND: pix_nx = {ALPHA_OPAQUE, div255(mix_s2.sum[2]),
				                    div255(mix_s2.sum[1]), div255(mix_s2.sum[0])};
				default:  pix_nx = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_o) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_o) begin
			we_q       <= we_nx;
			dst_addr_q <= addr_s2.dst_addr;
			// source address wraps at 24 bits
			src_addr_q <= addr_s2.src_prod + 24'(addr_s2.src_off);
			pix_q      <= pix_nx;
			last_q     <= last_s2;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, pix_q, src_addr_q, dst_addr_q, we_q};
	assign m_tlast  = last_q;

	// written pixels always carry full alpha
	`CLB_ASSERT_NOW(a_we_opaque, m_tvalid && m_tdata[0], m_tdata[76:69] == ALPHA_OPAQUE, "written pixel alpha is not 0xFF")

	// no write means a zero colour
	`CLB_ASSERT_NOW(a_nowrite_zero, m_tvalid && !m_tdata[0], m_tdata[76:45] == 32'd0, "non-written pixel is not zero")

	// after the last position the walk restarts at the origin
	`CLB_ASSERT_NEXT(a_wrap_origin, accept && pos.last, pos.col == 11'd0 && pos.row == 11'd0, "walker did not return to origin after last")

endmodule

>>> hw/rtl/clb_cfg_regs.sv
module clb_cfg_regs import clb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [11:0] dest_x_q, dest_y_q, rect_w_q, rect_h_q, src_x_q, src_y_q;
	logic [12:0] src_width_q;

	// 0 acts as 1, anything above 2048 as 2048
	function automatic logic [11:0] eff_len(input logic [11:0] v);
		logic [11:0] r;
		if (v == 12'd0) begin
			r = 12'd1;
		end else if (v > 12'd2048) begin
			r = 12'd2048;
		end else begin
			r = v;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q    <= '0;
			dest_y_q    <= '0;
			rect_w_q    <= 12'd1;
			rect_h_q    <= 12'd1;
			src_x_q     <= '0;
			src_y_q     <= '0;
			src_width_q <= 13'd1;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEST_X:    dest_x_q    <= cfg_data[11:0];
				REG_DEST_Y:    dest_y_q    <= cfg_data[11:0];
				REG_RECT_W:    rect_w_q    <= cfg_data[11:0];
				REG_RECT_H:    rect_h_q    <= cfg_data[11:0];
				REG_SRC_X:     src_x_q     <= cfg_data[11:0];
				REG_SRC_Y:     src_y_q     <= cfg_data[11:0];
				REG_SRC_WIDTH: src_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.dest_x    = dest_x_q;
	assign cfg.dest_y    = dest_y_q;
	assign cfg.rect_w    = eff_len(rect_w_q);
	assign cfg.rect_h    = eff_len(rect_h_q);
	assign cfg.src_x     = src_x_q;
	assign cfg.src_y     = src_y_q;
	assign cfg.src_width = src_width_q;

endmodule

>>> hw/rtl/clb_walker.sv
module clb_walker import clb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic step,
	output pos_t pos
);

	logic [10:0] col_q, row_q;
	logic [11:0] col_nx, row_nx;
	logic        row_end, rect_end;

	assign col_nx   = {1'b0, col_q} + 12'd1;
	assign row_nx   = {1'b0, row_q} + 12'd1;
	// >= so a counter past a shrunk bound still closes out
	assign row_end  = col_nx >= cfg.rect_w;
	assign rect_end = row_nx >= cfg.rect_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= rect_end ? 11'd0 : row_nx[10:0];
			end else begin
				col_q <= col_nx[10:0];
			end
		end
	end

	assign pos.col  = col_q;
	assign pos.row  = row_q;
	assign pos.last = row_end && rect_end;

endmodule

>>> hw/rtl/clb_addr_gen.sv
module clb_addr_gen import clb_pkg::*; (
	input  cfg_t        cfg,
	input  logic [10:0] col,
	input  logic [10:0] row,
	output addr_t       addr
);

	logic [12:0] dx, dy;
	logic [12:0] src_row;
	logic [25:0] prod;

	// window position, 13-bit two's complement
	assign dx = {cfg.dest_x[11], cfg.dest_x} + {2'b00, col};
	assign dy = {cfg.dest_y[11], cfg.dest_y} + {2'b00, row};

	assign addr.in_win = !dx[12] && (dx[11:0] < 12'(WIN_WIDTH)) &&
	                     !dy[12] && (dy[11:0] < 12'(WIN_HEIGHT));

	assign addr.dst_addr = addr.in_win ?
		20'(20'(dy[11:0]) * 20'(WIN_WIDTH)) + 20'(dx[11:0]) : 20'd0;

	// source row times pitch; column offset is added a stage later
	assign src_row       = {1'b0, cfg.src_y} + {2'b00, row};
	assign prod          = 26'(src_row) * 26'(cfg.src_width);
	assign addr.src_prod = prod[23:0];
	assign addr.src_off  = {1'b0, cfg.src_x} + {2'b00, col};

endmodule

>>> hw/rtl/clb_mix.sv
module clb_mix import clb_pkg::*; (
	input  logic [31:0] src_pixel,
	input  logic [31:0] dst_pixel,
	output mix_t        mix
);

	logic [7:0] a, na;

	assign a  = src_pixel[31:24];
	assign na = ALPHA_OPAQUE - a;

	assign mix.kind = (a == ALPHA_CLEAR)  ? PX_CLEAR :
	                  (a == ALPHA_OPAQUE) ? PX_COPY  : PX_BLEND;

	// R, G, B lanes; each sum stays at or below 255*255
	for (genvar c = 0; c < 3; c++) begin : g_chan
		assign mix.sum[c] = 16'(src_pixel[8*c +: 8]) * 16'(a) +
		                    16'(dst_pixel[8*c +: 8]) * 16'(na);
	end

endmodule
